@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define KRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/krt_pkg.sv @@
package krt_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_STORE  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // one table entry as held in memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

@@ hdl/keyed_registration_table.sv @@
// flow: a command goes from idle to the scan, or for a clear straight to the response state;
//   a remove that moves the last entry passes through the move state before the response
// throughput: one command at a time, the scan reads one memory entry per cycle through the
//   single read port; a new command waits until the result reaches the output register
// reset: synchronous active low, clears the fill count and control state only;
//   memory contents are never cleared, entries at or above the fill count are never compared
`include "assert_macros.svh"

module keyed_registration_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_entry_key,
  input  logic signed [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_found_value,
  output logic [4:0]  out_entry_count
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RESP
  } state_t;

  // control and payload registers
  state_t                 state_r, state_nxt;
  krt_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [31:0]            val_r, val_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  krt_pkg::status_t       res_status_r, res_status_nxt;
  logic [31:0]            res_found_r, res_found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [31:0]            out_found_r, out_found_nxt;
  logic [4:0]             out_count_r, out_count_nxt;

  // memory port signals
  krt_pkg::entry_t        mem [CAPACITY];
  krt_pkg::entry_t        rd_data_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  krt_pkg::entry_t        wr_data;

  // scan decode
  logic                   hit;
  logic                   last_probe;
  logic [CNT_W-1:0]       last_cnt;
  logic [CNT_W+4:0]       count_ext;

  assign hit        = (count_r != '0) && (rd_data_r.key == key_r);
  assign last_probe = ((CNT_W'(pend_idx_r) + CNT_W'(1)) >= count_r);
  assign last_cnt   = count_r - CNT_W'(1);
  assign count_ext  = {5'd0, count_nxt};

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_count_r;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    pend_idx_nxt   = pend_idx_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    rd_addr        = IDX_W'(pend_idx_r + IDX_W'(1));
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    // output transfer frees the result register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          cmd_nxt       = krt_pkg::cmd_t'(in_command);
          key_nxt       = in_entry_key;
          val_nxt       = in_entry_value;
          res_found_nxt = '0;
          pend_idx_nxt  = '0;
          if (krt_pkg::cmd_t'(in_command) == krt_pkg::CMD_CLEAR) begin
            count_nxt      = '0;
            res_status_nxt = krt_pkg::ST_DONE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // compare the entry read last cycle while the next read is in flight
        if (hit) begin
          res_status_nxt = krt_pkg::ST_DONE;
          state_nxt      = S_RESP;
          unique case (cmd_r)
            krt_pkg::CMD_STORE: begin
              wr_en   = 1'b1;
              wr_addr = pend_idx_r;
              wr_data = '{key: key_r, value: val_r};
            end
            krt_pkg::CMD_LOOKUP: begin
              res_found_nxt = rd_data_r.value;
            end
            krt_pkg::CMD_REMOVE: begin
              slot_nxt = pend_idx_r;
              if (CNT_W'(pend_idx_r) == last_cnt) begin
                count_nxt = last_cnt;
              end else begin
                rd_addr   = last_cnt[IDX_W-1:0];
                state_nxt = S_MOVE;
              end
            end
            default: begin
            end
          endcase
        end else if (last_probe) begin
          state_nxt = S_RESP;
          unique case (cmd_r)
            krt_pkg::CMD_STORE: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = krt_pkg::ST_FULL;
              end else begin
                res_status_nxt = krt_pkg::ST_DONE;
                wr_en          = 1'b1;
                wr_addr        = count_r[IDX_W-1:0];
                wr_data        = '{key: key_r, value: val_r};
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            default: begin
              res_status_nxt = krt_pkg::ST_MISSING;
            end
          endcase
        end else begin
          pend_idx_nxt = IDX_W'(pend_idx_r + IDX_W'(1));
        end
      end

      S_MOVE: begin
        // last entry fills the hole left by the removed key
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_data   = rd_data_r;
        count_nxt = last_cnt;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_count_nxt  = count_ext[4:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result count follows the final count of the command
    if (state_r == S_RESP) begin
      out_count_nxt = (!out_valid_r || out_ready) ? count_ext[4:0] : out_count_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    pend_idx_r   <= pend_idx_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // fill count never passes the table size
  `KRT_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  // an input transfer always starts a scan or a clear response
  `KRT_ASSERT_NEXT(a_accept_next, clk, rst_n, in_valid && in_ready, (state_r == S_SCAN) || (state_r == S_RESP))
  // the memory is only written while a command is being worked
  `KRT_ASSERT_IMPL(a_write_busy, clk, rst_n, wr_en, (state_r == S_SCAN) || (state_r == S_MOVE))
  // the count is settled once the response is pending
  `KRT_ASSERT_NEXT(a_count_hold, clk, rst_n, state_r == S_RESP, $stable(count_r))

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // one expected reply of the table
  typedef struct {
    krt_pkg::status_t                   status;
    logic signed [krt_pkg::VALUE_W-1:0] value;
    logic [krt_pkg::COUNT_W-1:0]        count;
  } reply_t;

  // shadow copy of the table plus the queue of replies it predicts
  class reg_table_tracker;
    logic [krt_pkg::KEY_W-1:0]          keys [TABLE_DEPTH];
    logic signed [krt_pkg::VALUE_W-1:0] vals [TABLE_DEPTH];
    int unsigned               fill;
    reply_t                    pending_replies [$];
    int unsigned mismatches, replies_seen, hits, misses, full_refusals;
    int unsigned updates, clears, times_full;

    function new();
      clear_table();
    endfunction

    function void clear_table();
      foreach (keys[i]) begin
        keys[i] = '0;
        vals[i] = '0;
      end
      fill = 0;
    endfunction

    // first valid slot holding the key, or -1
    function int slot_of(logic [krt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    // accepted command: update the shadow table and queue the reply
    function void apply_command(krt_pkg::cmd_t c, logic [krt_pkg::KEY_W-1:0] key,
                                logic signed [krt_pkg::VALUE_W-1:0] val);
      reply_t r;
      int     slot;
      r.status = krt_pkg::ST_DONE;
      r.value  = '0;
      slot     = slot_of(key);
      case (c)
        krt_pkg::CMD_STORE: begin
          if (slot >= 0) begin
            vals[slot] = val;
            updates++;
          end else if (fill >= TABLE_DEPTH) begin
            r.status = krt_pkg::ST_FULL;
            full_refusals++;
          end else begin
            keys[fill] = key;
            vals[fill] = val;
            fill++;
            if (fill == TABLE_DEPTH) times_full++;
          end
        end
        krt_pkg::CMD_LOOKUP: begin
          if (slot >= 0) begin
            r.value = vals[slot];
            hits++;
          end else begin
            r.status = krt_pkg::ST_MISSING;
            misses++;
          end
        end
        krt_pkg::CMD_REMOVE: begin
          // last entry moves into the hole
          if (slot >= 0) begin
            keys[slot]   = keys[fill-1];
            vals[slot]   = vals[fill-1];
            keys[fill-1] = '0;
            vals[fill-1] = '0;
            fill--;
          end else begin
            r.status = krt_pkg::ST_MISSING;
            misses++;
          end
        end
        default: begin
          clear_table();
          clears++;
        end
      endcase
      r.count = krt_pkg::COUNT_W'(fill);
      pending_replies.push_back(r);
    endfunction

    // result transfer: compare with the oldest expected reply
    function void check_reply(logic [1:0] status, logic signed [krt_pkg::VALUE_W-1:0] value,
                              logic [krt_pkg::COUNT_W-1:0] count);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $error("unexpected result transfer: status %0d found_value %0d entry_count %0d",
               status, value, count);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      replies_seen++;
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("found_value: expected %0d, got %0d", e.value, value);
        mismatches++;
      end
      if (count !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, count);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_command = krt_pkg::CMD_LOOKUP;
  logic [krt_pkg::KEY_W-1:0]          in_entry_key = '0;
  logic signed [krt_pkg::VALUE_W-1:0] in_entry_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [1:0]                         out_status;
  logic signed [krt_pkg::VALUE_W-1:0] out_found_value;
  logic [krt_pkg::COUNT_W-1:0]        out_entry_count;

  logic                      steady = 1'b0;
  int unsigned               cycle_count = 0;
  logic [krt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  reg_table_tracker          tracker;

  keyed_registration_table #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_entry_key   (in_entry_key),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_value(out_found_value),
    .out_entry_count(out_entry_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver stalls at random outside the steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_reply(out_status, out_found_value, out_entry_count);
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // one command transfer, with random idle cycles ahead of it outside the steady stretch
  task automatic send(input krt_pkg::cmd_t c, input logic [krt_pkg::KEY_W-1:0] key,
                      input logic signed [krt_pkg::VALUE_W-1:0] val);
    if (!steady) begin
      while ($urandom_range(0, 99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_command     <= c;
    in_entry_key   <= key;
    in_entry_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.apply_command(c, key, val);
    @(negedge clk);
  endtask

  // hold off the sender until every reply is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // extremes, every command and the corner cases of the table
  task automatic run_directed();
    send(krt_pkg::CMD_LOOKUP, 32'h0000_0000, 32'sd5);          // lookup on empty table
    send(krt_pkg::CMD_REMOVE, 32'h0000_0005, 32'sd0);          // remove on empty table
    send(krt_pkg::CMD_STORE,  32'h0000_0000, 32'sh7FFF_FFFF);  // key zero, max value
    send(krt_pkg::CMD_STORE,  32'hFFFF_FFFF, 32'sh8000_0000);  // all-ones key, min value
    send(krt_pkg::CMD_LOOKUP, 32'h0000_0000, 32'sd0);
    send(krt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'sd0);
    send(krt_pkg::CMD_STORE,  32'h0000_0000, -32'sd1);         // update in place
    // fill up to capacity
    for (int k = 0; k < TABLE_DEPTH - 2; k++) begin
      send(krt_pkg::CMD_STORE, 32'hA5A5_0000 ^ (32'h1 << (k + 2)), $signed($urandom));
    end
    send(krt_pkg::CMD_STORE,  32'h1234_5678, 32'sd77);         // absent key while full
    send(krt_pkg::CMD_STORE,  32'hFFFF_FFFF, 32'sd123);        // present key while full
    send(krt_pkg::CMD_REMOVE, 32'h0000_0000, 32'sd0);          // first slot, last moves in
    send(krt_pkg::CMD_LOOKUP, 32'hA5A5_0000 ^ (32'h1 << (TABLE_DEPTH - 1)), 32'sd0);
    send(krt_pkg::CMD_CLEAR,  $urandom, $signed($urandom));
    send(krt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'sd0);          // gone after clear
  endtask

  // random command with keys mostly from a small pool so that hits and full happen
  task automatic send_random(input int unsigned idx);
    krt_pkg::cmd_t             c;
    logic [krt_pkg::KEY_W-1:0] key;
    int unsigned               roll, store_pct;
    store_pct = ((idx / 150) % 2 == 0) ? 55 : 30;
    roll = $urandom_range(0, 99);
    if (roll < 3)                                         c = krt_pkg::CMD_CLEAR;
    else if (roll < 3 + store_pct)                        c = krt_pkg::CMD_STORE;
    else if (roll < 3 + store_pct + (97 - store_pct) / 2) c = krt_pkg::CMD_LOOKUP;
    else                                                  c = krt_pkg::CMD_REMOVE;
    if ($urandom_range(0, 99) < 12) key = $urandom;
    else                            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send(c, key, $signed($urandom));
  endtask

  initial begin
    tracker = new();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= (i >= 400 && i < 650);
      if (i == 700) hold_until_drained();
      send_random(i);
    end
    in_valid <= 1'b0;

    // drain and watch for stray results
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands checked: %0d lookups hit, %0d lookups or removes missed",
             tracker.replies_seen, tracker.hits, tracker.misses);
    $display("%0d in-place updates, table full %0d times, %0d refused stores, %0d clears",
             tracker.updates, tracker.times_full, tracker.full_refusals, tracker.clears);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
